>>> design/bwb_pkg.sv
// shared types and constants for the breakpoint / watchpoint bitmap
package bwb_pkg;

   localparam int ADDR_IN_WIDTH = 16;
   localparam int TOTAL_WIDTH   = 17;
   localparam int ROW_BITS      = 8;
   localparam int BIT_SEL_WIDTH = 3;

   typedef enum logic [3:0] {
      OP_CHECK_BREAK = 4'd0,
      OP_CHECK_WATCH = 4'd1,
      OP_ADD_BREAK   = 4'd2,
      OP_DEL_BREAK   = 4'd3,
      OP_ADD_WATCH   = 4'd4,
      OP_DEL_WATCH   = 4'd5,
      OP_CLR_BREAKS  = 4'd6,
      OP_CLR_WATCHES = 4'd7,
      OP_ARM_STEP    = 4'd8
   } op_code_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

endpackage

>>> design/bwb_channels.sv
// request and response channel interfaces
interface bwb_req_if
   import bwb_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [3:0]               req_type;
   logic [ADDR_IN_WIDTH-1:0] addr;

   modport source (output valid, output req_type, output addr, input ready);
   modport sink   (input valid, input req_type, input addr, output ready);
endinterface

interface bwb_rsp_if
   import bwb_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [TOTAL_WIDTH-1:0] break_total;
   logic [TOTAL_WIDTH-1:0] watch_total;

   modport source (output valid, output hit, output break_total, output watch_total,
                   input ready);
   modport sink   (input valid, input hit, input break_total, input watch_total,
                   output ready);
endinterface

>>> design/bwb_map_ram.sv
// single-port-write, single-port-read map memory with registered read data
module bwb_map_ram #(
   parameter int ROW_ADDR_WIDTH = 13,
   parameter int ROW_WIDTH      = 8
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [ROW_ADDR_WIDTH-1:0] rd_addr,
   output logic [ROW_WIDTH-1:0]      rd_data,
   input  logic                      wr_en,
   input  logic [ROW_ADDR_WIDTH-1:0] wr_addr,
   input  logic [ROW_WIDTH-1:0]      wr_data
);

   logic [ROW_WIDTH-1:0] mem [2**ROW_ADDR_WIDTH];
   logic [ROW_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/breakpoint_watchpoint_bitmap.sv
// top level: breakpoint and watchpoint bitmaps with counts and one-shot step target
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   req_type[3:0], addr[15:0]
//   rsp_chan  out  valid/ready   hit, break_total[16:0], watch_total[16:0]
//
// a request is one read-modify-write pass over the map memories: the
// accept edge reads the map row; in the exec state, once the response
// register is free, the row is modified, written back and the response loaded
// clear breaks / clear watches add a sweep of all 2**(ADDR_WIDTH-3) rows
// (8192 at the default) after the response is loaded, one row a cycle
// reset is synchronous; after reset both maps are swept the same way,
// with ready low
// a stalled response holds; a new request is still taken while it waits
module breakpoint_watchpoint_bitmap
   import bwb_pkg::*;
#(
   parameter int ADDR_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   bwb_req_if.sink    req_chan,
   bwb_rsp_if.source  rsp_chan
);

   localparam int ROW_ADDR_WIDTH = ADDR_WIDTH - BIT_SEL_WIDTH;
   localparam int CNT_WIDTH      = ADDR_WIDTH + 1;
   localparam logic [CNT_WIDTH-1:0] MAP_SIZE = {1'b1, {ADDR_WIDTH{1'b0}}};

   // control and state registers
   ctrl_state_type            state_ff, state_in;
   logic [ROW_ADDR_WIDTH-1:0] sweep_row_ff, sweep_row_in;
   logic                      sweep_break_ff, sweep_break_in;
   logic                      sweep_watch_ff, sweep_watch_in;
   logic [CNT_WIDTH-1:0]      break_count_ff, break_count_in;
   logic [CNT_WIDTH-1:0]      watch_count_ff, watch_count_in;
   logic [ADDR_WIDTH-1:0]     step_target_ff, step_target_in;
   logic                      step_perm_ff, step_perm_in;
   logic                      step_armed_ff, step_armed_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // payload registers
   op_code_type               op_ff;
   logic [ADDR_WIDTH-1:0]     addr_ff;
   logic                      rsp_hit_ff, rsp_hit_in;
   logic [TOTAL_WIDTH-1:0]    rsp_break_ff, rsp_break_in;
   logic [TOTAL_WIDTH-1:0]    rsp_watch_ff, rsp_watch_in;

   logic                      accept;
   logic [ADDR_WIDTH-1:0]     req_addr;
   logic [ROW_BITS-1:0]       break_rd, watch_rd;
   logic                      break_wr_en, watch_wr_en;
   logic [ROW_ADDR_WIDTH-1:0] wr_row;
   logic [ROW_BITS-1:0]       break_wr_data, watch_wr_data;

   // exec-stage working values
   logic [BIT_SEL_WIDTH-1:0]  bit_sel;
   logic                      break_bit, watch_bit, on_target, can_load;
   logic [ROW_BITS-1:0]       break_mod, watch_mod;
   logic                      break_mod_en, watch_mod_en;

   assign req_addr = ADDR_WIDTH'(req_chan.addr);
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.break_total = rsp_break_ff;
   assign rsp_chan.watch_total = rsp_watch_ff;

   // map memories, one row of eight addresses per word
   bwb_map_ram #(.ROW_ADDR_WIDTH(ROW_ADDR_WIDTH), .ROW_WIDTH(ROW_BITS)) u_break_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_addr[ADDR_WIDTH-1:BIT_SEL_WIDTH]),
      .rd_data (break_rd),
      .wr_en   (break_wr_en),
      .wr_addr (wr_row),
      .wr_data (break_wr_data)
   );

   bwb_map_ram #(.ROW_ADDR_WIDTH(ROW_ADDR_WIDTH), .ROW_WIDTH(ROW_BITS)) u_watch_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_addr[ADDR_WIDTH-1:BIT_SEL_WIDTH]),
      .rd_data (watch_rd),
      .wr_en   (watch_wr_en),
      .wr_addr (wr_row),
      .wr_data (watch_wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         sweep_row_ff   <= '0;
         sweep_break_ff <= 1'b1;
         sweep_watch_ff <= 1'b1;
         break_count_ff <= '0;
         watch_count_ff <= '0;
         step_target_ff <= '0;
         step_perm_ff   <= 1'b0;
         step_armed_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sweep_row_ff   <= sweep_row_in;
         sweep_break_ff <= sweep_break_in;
         sweep_watch_ff <= sweep_watch_in;
         break_count_ff <= break_count_in;
         watch_count_ff <= watch_count_in;
         step_target_ff <= step_target_in;
         step_perm_ff   <= step_perm_in;
         step_armed_ff  <= step_armed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_code_type'(req_chan.req_type);
         addr_ff <= req_addr;
      end
      rsp_hit_ff   <= rsp_hit_in;
      rsp_break_ff <= rsp_break_in;
      rsp_watch_ff <= rsp_watch_in;
   end

   always_comb begin
      state_in       = state_ff;
      sweep_row_in   = sweep_row_ff;
      sweep_break_in = sweep_break_ff;
      sweep_watch_in = sweep_watch_ff;
      break_count_in = break_count_ff;
      watch_count_in = watch_count_ff;
      step_target_in = step_target_ff;
      step_perm_in   = step_perm_ff;
      step_armed_in  = step_armed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_break_in   = rsp_break_ff;
      rsp_watch_in   = rsp_watch_ff;

      bit_sel   = addr_ff[BIT_SEL_WIDTH-1:0];
      break_bit = break_rd[bit_sel];
      watch_bit = watch_rd[bit_sel];
      on_target = step_armed_ff && (addr_ff == step_target_ff);
      can_load  = !rsp_valid_ff || rsp_chan.ready;

      break_mod    = break_rd;
      watch_mod    = watch_rd;
      break_mod_en = 1'b0;
      watch_mod_en = 1'b0;

      break_wr_en   = 1'b0;
      watch_wr_en   = 1'b0;
      wr_row        = addr_ff[ADDR_WIDTH-1:BIT_SEL_WIDTH];
      break_wr_data = break_mod;
      watch_wr_data = watch_mod;

      case (state_ff)
         ST_SWEEP: begin
            // zero one row of each selected map per cycle
            wr_row        = sweep_row_ff;
            break_wr_en   = sweep_break_ff;
            watch_wr_en   = sweep_watch_ff;
            break_wr_data = '0;
            watch_wr_data = '0;
            sweep_row_in  = sweep_row_ff + 1'b1;
            if (&sweep_row_ff) begin
               state_in       = ST_IDLE;
               sweep_break_in = 1'b0;
               sweep_watch_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (can_load) begin
               rsp_hit_in = 1'b0;
               state_in   = ST_IDLE;
               case (op_ff)
                  OP_CHECK_BREAK: begin
                     if ((break_count_ff != '0) && break_bit) begin
                        rsp_hit_in = 1'b1;
                        // one-shot hit: disarm, drop the bit unless it was permanent
                        if (on_target) begin
                           if (!step_perm_ff) begin
                              break_mod[bit_sel] = 1'b0;
                              break_mod_en       = 1'b1;
                              if (break_count_ff != '0) begin
                                 break_count_in = break_count_ff - 1'b1;
                              end
                           end
                           step_armed_in = 1'b0;
                        end
                     end
                  end
                  OP_CHECK_WATCH: begin
                     rsp_hit_in = (watch_count_ff != '0) && watch_bit;
                  end
                  OP_ADD_BREAK, OP_ARM_STEP: begin
                     rsp_hit_in = break_bit;
                     if (!break_bit) begin
                        break_mod[bit_sel] = 1'b1;
                        break_mod_en       = 1'b1;
                        if (break_count_ff < MAP_SIZE) begin
                           break_count_in = break_count_ff + 1'b1;
                        end
                     end
                     if (op_ff == OP_ADD_BREAK) begin
                        if (on_target) begin
                           step_perm_in = 1'b1;
                        end
                     end else begin
                        // rearm at the same target keeps its permanence
                        if (!on_target) begin
                           step_perm_in = break_bit;
                        end
                        step_target_in = addr_ff;
                        step_armed_in  = 1'b1;
                     end
                  end
                  OP_DEL_BREAK: begin
                     rsp_hit_in = break_bit;
                     if (break_bit) begin
                        break_mod[bit_sel] = 1'b0;
                        break_mod_en       = 1'b1;
                        if (break_count_ff != '0) begin
                           break_count_in = break_count_ff - 1'b1;
                        end
                     end
                     if (on_target) begin
                        step_armed_in = 1'b0;
                     end
                  end
                  OP_ADD_WATCH: begin
                     rsp_hit_in = watch_bit;
                     if (!watch_bit) begin
                        watch_mod[bit_sel] = 1'b1;
                        watch_mod_en       = 1'b1;
                        if (watch_count_ff < MAP_SIZE) begin
                           watch_count_in = watch_count_ff + 1'b1;
                        end
                     end
                  end
                  OP_DEL_WATCH: begin
                     rsp_hit_in = watch_bit;
                     if (watch_bit) begin
                        watch_mod[bit_sel] = 1'b0;
                        watch_mod_en       = 1'b1;
                        if (watch_count_ff != '0) begin
                           watch_count_in = watch_count_ff - 1'b1;
                        end
                     end
                  end
                  OP_CLR_BREAKS: begin
                     break_count_in = '0;
                     step_armed_in  = 1'b0;
                     sweep_break_in = 1'b1;
                     sweep_row_in   = '0;
                     state_in       = ST_SWEEP;
                  end
                  OP_CLR_WATCHES: begin
                     watch_count_in = '0;
                     sweep_watch_in = 1'b1;
                     sweep_row_in   = '0;
                     state_in       = ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
               break_wr_en   = break_mod_en;
               watch_wr_en   = watch_mod_en;
               break_wr_data = break_mod;
               watch_wr_data = watch_mod;
               rsp_valid_in  = 1'b1;
               rsp_break_in  = TOTAL_WIDTH'(break_count_in);
               rsp_watch_in  = TOTAL_WIDTH'(watch_count_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> verif/breakpoint_watchpoint_bitmap_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the breakpoint / watchpoint bitmap block
module breakpoint_watchpoint_bitmap_tb;
   import bwb_pkg::*;

   localparam int MAP_SIZE     = 1 << ADDR_IN_WIDTH;
   localparam int BREAK_MAP    = 0;
   localparam int WATCH_MAP    = 1;
   localparam int HOT_ADDRS    = 24;
   localparam int RANDOM_REQS  = 1900;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_REPORTS  = 50;
   localparam logic [3:0] FIRST_UNUSED_OP = 4'd9;
   localparam logic [3:0] LAST_UNUSED_OP  = 4'd15;

   typedef struct packed {
      logic [3:0]               code;
      logic [ADDR_IN_WIDTH-1:0] addr;
   } bitmap_req_type;

   typedef struct packed {
      logic                   hit;
      logic [TOTAL_WIDTH-1:0] break_total;
      logic [TOTAL_WIDTH-1:0] watch_total;
   } bitmap_answer_type;

   // clock and reset; reset is high from time zero and released once
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // request side drive registers, all known from time zero
   logic                     send_valid = 1'b0;
   logic [3:0]               send_type  = '0;
   logic [ADDR_IN_WIDTH-1:0] send_addr  = '0;
   logic                     take_ready = 1'b0;

   bwb_req_if req_chan ();
   bwb_rsp_if rsp_chan ();

   assign req_chan.valid    = send_valid;
   assign req_chan.req_type = send_type;
   assign req_chan.addr     = send_addr;
   assign rsp_chan.ready    = take_ready;

   breakpoint_watchpoint_bitmap dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // requests waiting to be driven and answers waiting to come back
   bitmap_req_type    pending_reqs [$];
   bitmap_answer_type predicted_answers [$];

   int mismatch_count = 0;
   int issued_reqs    = 0;
   int total_reqs     = 1;
   int idle_phase     = 0;
   bit req_taken      = 1'b0;

   // shadow copy of the block state, matching its reset values
   bit                       bitmap [2][MAP_SIZE];
   logic [TOTAL_WIDTH-1:0]   entry_count [2] = '{'0, '0};
   logic [ADDR_IN_WIDTH-1:0] step_target    = '0;
   bit                       step_permanent = 1'b0;
   bit                       step_armed     = 1'b0;

   task automatic report_mismatch(string msg);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic void push_req(logic [3:0] code, logic [ADDR_IN_WIDTH-1:0] a);
      pending_reqs.push_back('{code, a});
   endfunction

   // idle percentage per phase: sender light / receiver heavy, then swapped, then none
   function automatic int idle_pct(bit sender, int phase);
      case (phase)
         0:       return sender ? 26 : 82;
         1:       return sender ? 82 : 26;
         default: return 0;
      endcase
   endfunction

   // set or clear one map bit, keeping the count; returns the bit before the change
   function automatic bit change_entry(int m, logic [ADDR_IN_WIDTH-1:0] a, bit set);
      bit was;
      was = bitmap[m][a];
      if (set && !was) begin
         bitmap[m][a] = 1'b1;
         if (entry_count[m] < MAP_SIZE) entry_count[m]++;
      end else if (!set && was) begin
         bitmap[m][a] = 1'b0;
         if (entry_count[m] != 0) entry_count[m]--;
      end
      return was;
   endfunction

   function automatic void clear_map(int m);
      for (int i = 0; i < MAP_SIZE; i++) bitmap[m][i] = 1'b0;
      entry_count[m] = '0;
   endfunction

   // apply one accepted request to the shadow state and queue its answer
   task automatic model_request(logic [3:0] code, logic [ADDR_IN_WIDTH-1:0] a);
      bitmap_answer_type ans;
      bit                on_target;
      on_target = step_armed && a == step_target;
      ans.hit = 1'b0;
      case (code)
         OP_CHECK_BREAK: begin
            if (entry_count[BREAK_MAP] != 0 && bitmap[BREAK_MAP][a]) begin
               ans.hit = 1'b1;
               // one-shot hit: drop the bit unless a permanent breakpoint shares it
               if (on_target) begin
                  if (!step_permanent) void'(change_entry(BREAK_MAP, a, 1'b0));
                  step_armed = 1'b0;
               end
            end
         end
         OP_CHECK_WATCH: begin
            ans.hit = entry_count[WATCH_MAP] != 0 && bitmap[WATCH_MAP][a];
         end
         OP_ADD_BREAK: begin
            ans.hit = change_entry(BREAK_MAP, a, 1'b1);
            if (on_target) step_permanent = 1'b1;
         end
         OP_DEL_BREAK: begin
            ans.hit = change_entry(BREAK_MAP, a, 1'b0);
            if (on_target) step_armed = 1'b0;
         end
         OP_ADD_WATCH: ans.hit = change_entry(WATCH_MAP, a, 1'b1);
         OP_DEL_WATCH: ans.hit = change_entry(WATCH_MAP, a, 1'b0);
         OP_CLR_BREAKS: begin
            clear_map(BREAK_MAP);
            step_armed = 1'b0;
         end
         OP_CLR_WATCHES: clear_map(WATCH_MAP);
         OP_ARM_STEP: begin
            ans.hit = change_entry(BREAK_MAP, a, 1'b1);
            // re-arming the same target keeps its permanence flag
            if (!on_target) step_permanent = ans.hit;
            step_target = a;
            step_armed  = 1'b1;
         end
         default: ;
      endcase
      ans.break_total = entry_count[BREAK_MAP];
      ans.watch_total = entry_count[WATCH_MAP];
      predicted_answers.push_back(ans);
   endtask

   // driver: inputs change on the falling edge; hold while not accepted
   always @(negedge clock) begin : driver
      bitmap_req_type next_req;
      if (!reset && (!send_valid || req_taken)) begin
         if (pending_reqs.size() != 0 &&
             $urandom_range(0, 99) >= idle_pct(1'b1, idle_phase)) begin
            next_req = pending_reqs.pop_front();
            send_valid <= 1'b1;
            send_type  <= next_req.code;
            send_addr  <= next_req.addr;
            issued_reqs++;
            idle_phase <= (issued_reqs * 3) / total_reqs;
         end else begin
            send_valid <= 1'b0;
         end
      end
   end

   // response back-pressure, re-rolled every cycle
   always @(negedge clock) begin : receiver
      if (reset)
         take_ready <= 1'b0;
      else
         take_ready <= $urandom_range(0, 99) >= idle_pct(1'b0, idle_phase);
   end

   // monitor: sample both handshakes on the rising edge
   always @(posedge clock) begin : monitor
      bitmap_answer_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         // a response can never belong to the request accepted at the same edge
         if ((rsp_chan.valid && rsp_chan.ready) === 1'b1) begin
            if (predicted_answers.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = predicted_answers.pop_front();
               if (rsp_chan.hit !== want.hit)
                  report_mismatch($sformatf("hit got %b expected %b",
                                            rsp_chan.hit, want.hit));
               if (rsp_chan.break_total !== want.break_total)
                  report_mismatch($sformatf("break_total got %0d expected %0d",
                                            rsp_chan.break_total, want.break_total));
               if (rsp_chan.watch_total !== want.watch_total)
                  report_mismatch($sformatf("watch_total got %0d expected %0d",
                                            rsp_chan.watch_total, want.watch_total));
            end
         end
         req_taken = (req_chan.valid && req_chan.ready) === 1'b1;
         if (req_taken) model_request(req_chan.req_type, req_chan.addr);
      end
   end

   // stimulus, reset and end of run
   initial begin : run_control
      logic [ADDR_IN_WIDTH-1:0] hot_addr [HOT_ADDRS];
      logic [ADDR_IN_WIDTH-1:0] target;
      int                       directed;
      int                       pick;

      // directed part: field extremes, every request code, the corner cases
      push_req(OP_CHECK_BREAK, 16'h0000);   // empty map check
      push_req(OP_CHECK_WATCH, 16'hFFFF);
      push_req(OP_ADD_BREAK,   16'hFFFF);
      push_req(OP_ADD_BREAK,   16'hFFFF);   // add on a set bit
      push_req(OP_CHECK_BREAK, 16'hFFFF);
      push_req(OP_DEL_BREAK,   16'h0000);   // delete on a clear bit
      push_req(OP_ADD_WATCH,   16'h8000);
      push_req(OP_CHECK_WATCH, 16'h8000);
      push_req(OP_DEL_WATCH,   16'h8000);
      push_req(OP_DEL_WATCH,   16'h8000);
      push_req(OP_ARM_STEP,    16'h1234);   // plain one-shot
      push_req(OP_CHECK_BREAK, 16'h1234);
      push_req(OP_CHECK_BREAK, 16'h1234);
      push_req(OP_ARM_STEP,    16'hFFFF);   // one-shot on a permanent breakpoint
      push_req(OP_CHECK_BREAK, 16'hFFFF);
      push_req(OP_ARM_STEP,    16'h0AAA);
      push_req(OP_ADD_BREAK,   16'h0AAA);   // becomes permanent after arming
      push_req(OP_CHECK_BREAK, 16'h0AAA);
      push_req(OP_ARM_STEP,    16'h0F0F);
      push_req(OP_DEL_BREAK,   16'h0F0F);   // delete at target disarms
      push_req(OP_ARM_STEP,    16'h0456);
      push_req(OP_ARM_STEP,    16'h0123);   // old one-shot abandoned
      push_req(OP_ARM_STEP,    16'h0123);   // same target keeps its flag
      push_req(OP_CHECK_BREAK, 16'h0123);
      push_req(OP_ARM_STEP,    16'h5555);
      push_req(OP_CLR_BREAKS,  16'h5555);   // clear disarms too
      push_req(OP_CHECK_BREAK, 16'h5555);
      push_req(FIRST_UNUSED_OP, 16'hA5A5);
      push_req(LAST_UNUSED_OP,  16'h5A5A);
      push_req(OP_ADD_WATCH,   16'h0001);
      push_req(OP_CLR_WATCHES, 16'h0001);
      push_req(OP_CHECK_WATCH, 16'h0001);
      directed = pending_reqs.size();

      // a small pool of addresses so that adds, deletes and checks collide
      foreach (hot_addr[i]) hot_addr[i] = ADDR_IN_WIDTH'($urandom);
      hot_addr[0] = '0;
      hot_addr[1] = '1;

      while (pending_reqs.size() < directed + RANDOM_REQS) begin
         pick = $urandom_range(0, 99);
         if (pick < 1) begin
            // whole-map clears are slow, keep them rare
            push_req($urandom_range(0, 1) ? OP_CLR_WATCHES : OP_CLR_BREAKS,
                     ADDR_IN_WIDTH'($urandom));
         end else if (pick < 4) begin
            push_req(4'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP)),
                     ADDR_IN_WIDTH'($urandom));
         end else if (pick < 18) begin
            // step-over sequence: arm, some traffic, then fetch at the target
            target = hot_addr[$urandom_range(0, HOT_ADDRS - 1)];
            push_req(OP_ARM_STEP, target);
            repeat ($urandom_range(0, 3)) begin
               case ($urandom_range(0, 7))
                  0:       push_req(OP_ADD_BREAK, target);
                  1:       push_req(OP_DEL_BREAK, target);
                  2:       push_req(OP_ARM_STEP, target);
                  3:       push_req(OP_ARM_STEP, hot_addr[$urandom_range(0, HOT_ADDRS - 1)]);
                  4:       push_req(OP_CHECK_BREAK, target);
                  default: push_req(4'($urandom_range(OP_CHECK_BREAK, OP_DEL_WATCH)),
                                    hot_addr[$urandom_range(0, HOT_ADDRS - 1)]);
               endcase
            end
            push_req(OP_CHECK_BREAK, target);
            if ($urandom_range(0, 1)) push_req(OP_CHECK_BREAK, target);
         end else if (pick < 28) begin
            // anywhere in the address space
            if ($urandom_range(0, 6) == 0)
               push_req(OP_ARM_STEP, ADDR_IN_WIDTH'($urandom));
            else
               push_req(4'($urandom_range(OP_CHECK_BREAK, OP_DEL_WATCH)),
                        ADDR_IN_WIDTH'($urandom));
         end else begin
            push_req(4'($urandom_range(OP_CHECK_BREAK, OP_DEL_WATCH)),
                     hot_addr[$urandom_range(0, HOT_ADDRS - 1)]);
         end
      end
      total_reqs = pending_reqs.size();

      // synchronous reset, released away from the rising edge
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all requests accepted, then all answers back, then a short drain
      while (pending_reqs.size() != 0 || send_valid) @(posedge clock);
      while (predicted_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("breakpoint_watchpoint_bitmap test passed");
      else
         $display("breakpoint_watchpoint_bitmap test failed");
      $finish;
   end

   // hang guard, far beyond the slowest legal run including the clear sweeps
   initial begin : watchdog
      #20ms;
      $display("breakpoint_watchpoint_bitmap test failed");
      $finish;
   end

endmodule
